FILE: rtl/dbps_pkg.sv
// Shared types and constants for the DCC bit and preamble sync block.
package dbps_pkg;

   localparam int PULSE_W = 16;
   localparam int COUNT_W = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [COUNT_W-1:0] ONES_MAX = 6'd63;

   localparam logic [CSR_INDEX_W-1:0] REG_SHORT_MIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SHORT_MAX = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_MIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_MAX = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PREAMBLE_ONES = 3'd4;

   localparam logic [PULSE_W-1:0] SHORT_MIN_RESET = 16'd1040;
   localparam logic [PULSE_W-1:0] SHORT_MAX_RESET = 16'd1280;
   localparam logic [PULSE_W-1:0] LONG_MIN_RESET = 16'd2000;
   localparam logic [PULSE_W-1:0] LONG_MAX_RESET = 16'd4000;
   localparam logic [COUNT_W-1:0] PREAMBLE_ONES_RESET = 6'd10;

   typedef enum logic [1:0] {
      KIND_LONG  = 2'd0,
      KIND_SHORT = 2'd1,
      KIND_BAD   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [PULSE_W-1:0] short_min;
      logic [PULSE_W-1:0] short_max;
      logic [PULSE_W-1:0] long_min;
      logic [PULSE_W-1:0] long_max;
   } window_type;

   typedef struct packed {
      logic               bit_done;
      logic               bit_value;
      logic               pulse_error;
      logic               start_found;
      logic               awaiting_start;
      logic [COUNT_W-1:0] ones_run;
   } result_type;

endpackage

FILE: rtl/dcc_bit_and_preamble_sync.sv
// Top level of the DCC bit decoder with preamble and start-bit detection.
// Each input word is one measured half-bit length and yields exactly one result word.
// The block takes one word per cycle while the pulse queue is not full; each word waits
// in the pulse queue and its result is then held in the output register. The queue of
// QUEUE_DEPTH entries lets the classifier keep taking words while a result waits to be
// taken. The user must write configuration registers through the csr port only while
// the block is idle; the block does not enforce this. Unknown register indexes are ignored.
module dcc_bit_and_preamble_sync #(
   parameter int QUEUE_DEPTH = dbps_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [dbps_pkg::PULSE_W-1:0]     req_pulse_length,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_bit_done,
   output logic                             rsp_bit_value,
   output logic                             rsp_pulse_error,
   output logic                             rsp_start_found,
   output logic                             rsp_awaiting_start,
   output logic [dbps_pkg::COUNT_W-1:0]     rsp_ones_run,
   input  logic                             csr_write,
   input  logic [dbps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dbps_pkg::CSR_DATA_W-1:0]  csr_data
);
   import dbps_pkg::*;

   window_type         window_ff;
   logic [COUNT_W-1:0] preamble_ones_ff;
   kind_type           front_kind;
   kind_type           back_kind;
   logic               queue_full;
   logic               queue_not_empty;
   logic               push;
   logic               pop;
   result_type         back_result;
   result_type         rsp_word_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff.short_min <= SHORT_MIN_RESET;
         window_ff.short_max <= SHORT_MAX_RESET;
         window_ff.long_min  <= LONG_MIN_RESET;
         window_ff.long_max  <= LONG_MAX_RESET;
         preamble_ones_ff    <= PREAMBLE_ONES_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_SHORT_MIN:     window_ff.short_min <= csr_data;
            REG_SHORT_MAX:     window_ff.short_max <= csr_data;
            REG_LONG_MIN:      window_ff.long_min <= csr_data;
            REG_LONG_MAX:      window_ff.long_max <= csr_data;
            REG_PREAMBLE_ONES: preamble_ones_ff <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   dbps_classify u_classify (
      .pulse_length (req_pulse_length),
      .window       (window_ff),
      .kind         (front_kind)
   );

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign pop       = queue_not_empty && (!rsp_valid_ff || !rsp_stall);

   dbps_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_kind (front_kind),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop_kind  (back_kind)
   );

   dbps_sync u_sync (
      .clock         (clock),
      .reset         (reset),
      .take          (pop),
      .kind          (back_kind),
      .preamble_ones (preamble_ones_ff),
      .result        (back_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_word_ff <= back_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bit_done       = rsp_word_ff.bit_done;
   assign rsp_bit_value      = rsp_word_ff.bit_value;
   assign rsp_pulse_error    = rsp_word_ff.pulse_error;
   assign rsp_start_found    = rsp_word_ff.start_found;
   assign rsp_awaiting_start = rsp_word_ff.awaiting_start;
   assign rsp_ones_run       = rsp_word_ff.ones_run;

endmodule

FILE: rtl/dbps_classify.sv
// Front end: sorts each pulse length into short, long or invalid.
module dbps_classify (
   input  logic [dbps_pkg::PULSE_W-1:0] pulse_length,
   input  dbps_pkg::window_type         window,
   output dbps_pkg::kind_type           kind
);
   import dbps_pkg::*;

   logic in_short;
   logic in_long;

   assign in_short = (pulse_length >= window.short_min) && (pulse_length <= window.short_max);
   assign in_long  = (pulse_length >= window.long_min) && (pulse_length <= window.long_max);

   // A length inside both windows counts as short.
   always_comb begin
      if (in_short) begin
         kind = KIND_SHORT;
      end else if (in_long) begin
         kind = KIND_LONG;
      end else begin
         kind = KIND_BAD;
      end
   end

endmodule

FILE: rtl/dbps_queue.sv
// Short queue of classified pulses between the front and back ends.
module dbps_queue #(
   parameter int DEPTH = dbps_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dbps_pkg::kind_type push_kind,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output dbps_pkg::kind_type pop_kind
);
   import dbps_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   kind_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == FULL_COUNT);
   assign not_empty = (count_ff != '0);
   assign pop_kind  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_kind;
      end
   end

endmodule

FILE: rtl/dbps_sync.sv
// Back end: pairs half-bits, counts the preamble and spots the start bit.
module dbps_sync (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  dbps_pkg::kind_type           kind,
   input  logic [dbps_pkg::COUNT_W-1:0] preamble_ones,
   output dbps_pkg::result_type         result
);
   import dbps_pkg::*;

   logic               half_pending_ff, half_pending_in;
   logic               half_value_ff, half_value_in;
   logic [COUNT_W-1:0] ones_count_ff, ones_count_in;
   logic               start_mode_ff, start_mode_in;
   logic               half_bit;

   always_comb begin
      half_pending_in = half_pending_ff;
      half_value_in   = half_value_ff;
      ones_count_in   = ones_count_ff;
      start_mode_in   = start_mode_ff;
      result          = '0;
      half_bit        = 1'b0;
      case (kind)
         KIND_SHORT: half_bit = 1'b1;
         KIND_LONG:  half_bit = 1'b0;
         default:    half_bit = 1'b0;
      endcase
      if (kind == KIND_BAD || (half_pending_ff && half_value_ff != half_bit)) begin
         result.pulse_error = 1'b1;
         half_pending_in    = 1'b0;
         half_value_in      = 1'b0;
         ones_count_in      = '0;
         start_mode_in      = 1'b0;
      end else if (!half_pending_ff) begin
         half_pending_in = 1'b1;
         half_value_in   = half_bit;
      end else begin
         half_pending_in  = 1'b0;
         result.bit_done  = 1'b1;
         result.bit_value = half_bit;
         if (half_bit) begin
            if (ones_count_ff != ONES_MAX) begin
               ones_count_in = ones_count_ff + 1'b1;
            end
            if (!start_mode_ff && ones_count_in >= preamble_ones) begin
               start_mode_in = 1'b1;
            end
         end else begin
            result.start_found = start_mode_ff;
            start_mode_in      = 1'b0;
            ones_count_in      = '0;
         end
      end
      result.awaiting_start = start_mode_in;
      result.ones_run       = ones_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_pending_ff <= 1'b0;
         half_value_ff   <= 1'b0;
         ones_count_ff   <= '0;
         start_mode_ff   <= 1'b0;
      end else if (take) begin
         half_pending_ff <= half_pending_in;
         half_value_ff   <= half_value_in;
         ones_count_ff   <= ones_count_in;
         start_mode_ff   <= start_mode_in;
      end
   end

endmodule
